### rtl/core/min_pq_pkg.sv
`timescale 1ns / 1ps

package min_pq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned PAYLOAD_W  = 32;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 48;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef struct packed {
    logic [PRIO_W-1:0]           prio;
    logic signed [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic shift_init;
    logic shift;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic shift_done;
  } dp_sts_t;

endpackage

### rtl/core/min_priority_queue.sv
`timescale 1ns / 1ps
// Insert, and any request that finds the queue full or empty: the result is registered into
// the result word once the output is free, and the next request can be taken after that load.
// Remove: the result word is loaded once the output is free, after a scan of the entry
// memory (one read a cycle) followed by a compaction pass that moves each later entry down one,
// and the next request can be taken after that load.
// Reset is asynchronous and active low; it empties the queue and drops any pending result.

module min_priority_queue #(
  parameter int unsigned DEPTH = min_pq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // priority_req [7:0], payload [39:8]
  input  logic [min_pq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_priority [7:0], out_payload [39:8], fill_level [44:40], zero [47:45]
  output logic [min_pq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // status [1:0]
  output logic [1:0]                          m_axis_tuser
);

  min_pq_pkg::dp_cmd_t                     cmd;
  min_pq_pkg::dp_sts_t                     sts;
  min_pq_pkg::status_e                     out_status;
  logic [min_pq_pkg::PRIO_W-1:0]           out_priority;
  logic signed [min_pq_pkg::PAYLOAD_W-1:0] out_payload;
  logic [min_pq_pkg::FILL_W-1:0]           out_fill;

  min_pq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  min_pq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_action_i    (s_axis_tuser),
    .in_priority_i  (s_axis_tdata[7:0]),
    .in_payload_i   (s_axis_tdata[39:8]),
    .sts_o          (sts),
    .out_status_o   (out_status),
    .out_priority_o (out_priority),
    .out_payload_o  (out_payload),
    .out_fill_o     (out_fill)
  );

  assign m_axis_tdata = {3'b000, out_fill, out_payload, out_priority};
  assign m_axis_tuser = out_status;

endmodule

### rtl/core/min_pq_ctrl.sv
`timescale 1ns / 1ps

module min_pq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  input  logic                out_ready_i,
  input  min_pq_pkg::dp_sts_t sts_i,
  output min_pq_pkg::dp_cmd_t cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if ((in_action_i == min_pq_pkg::ACT_REMOVE) && !sts_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/min_pq_dp.sv
`timescale 1ns / 1ps

module min_pq_dp #(
  parameter int unsigned DEPTH = min_pq_pkg::DEPTH_DEFAULT
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  min_pq_pkg::dp_cmd_t                         cmd_i,
  input  logic                                        in_action_i,
  input  logic        [min_pq_pkg::PRIO_W-1:0]        in_priority_i,
  input  logic signed [min_pq_pkg::PAYLOAD_W-1:0]     in_payload_i,
  output min_pq_pkg::dp_sts_t                         sts_o,
  output min_pq_pkg::status_e                         out_status_o,
  output logic        [min_pq_pkg::PRIO_W-1:0]        out_priority_o,
  output logic signed [min_pq_pkg::PAYLOAD_W-1:0]     out_payload_o,
  output logic        [min_pq_pkg::FILL_W-1:0]        out_fill_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  min_pq_pkg::entry_t mem_q [DEPTH];
  min_pq_pkg::entry_t rdata_q;
  min_pq_pkg::entry_t best_q;
  min_pq_pkg::entry_t wdata;
  logic [AW-1:0]      waddr;
  logic               we;
  logic               issue;
  logic               full;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] data_idx_q;
  logic [AW-1:0] best_idx_q;

  min_pq_pkg::status_e                     res_status_q;
  logic [min_pq_pkg::PRIO_W-1:0]           res_prio_q;
  logic signed [min_pq_pkg::PAYLOAD_W-1:0] res_payload_q;

  assign full  = (count_q == CW'(DEPTH));
  assign issue = (cmd_i.scan || cmd_i.shift) && (rd_ptr_q < count_q);

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = '{prio: in_priority_i, payload: in_payload_i};
    if (cmd_i.capture && (in_action_i == min_pq_pkg::ACT_INSERT) && !full) begin
      we = 1'b1;
    end else if (cmd_i.shift && dv_q) begin
      we    = 1'b1;
      waddr = data_idx_q - AW'(1);
      wdata = rdata_q;
    end
  end

  always_comb begin
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    dv_d     = 1'b0;
    if (cmd_i.capture) begin
      rd_ptr_d = '0;
      if ((in_action_i == min_pq_pkg::ACT_INSERT) && !full) begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.shift_init) begin
      rd_ptr_d = CW'(best_idx_q) + CW'(1);
    end else if (issue) begin
      rd_ptr_d = rd_ptr_q + CW'(1);
      dv_d     = 1'b1;
    end
    if (cmd_i.finish) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
      dv_q     <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      dv_q     <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q    <= mem_q[rd_ptr_q[AW-1:0]];
      data_idx_q <= rd_ptr_q[AW-1:0];
    end
  end

  // The earliest entry with the smallest priority is kept, so ties favor the oldest.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && dv_q) begin
      if ((data_idx_q == '0) || (rdata_q.prio < best_q.prio)) begin
        best_q     <= rdata_q;
        best_idx_q <= data_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_prio_q    <= '0;
      res_payload_q <= '0;
      if (in_action_i == min_pq_pkg::ACT_INSERT) begin
        res_status_q <= full ? min_pq_pkg::ST_FULL : min_pq_pkg::ST_INSERTED;
      end else begin
        res_status_q <= min_pq_pkg::ST_EMPTY;
      end
    end else if (cmd_i.finish) begin
      res_status_q  <= min_pq_pkg::ST_REMOVED;
      res_prio_q    <= best_q.prio;
      res_payload_q <= best_q.payload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_o   <= res_status_q;
      out_priority_o <= res_prio_q;
      out_payload_o  <= res_payload_q;
      out_fill_o     <= min_pq_pkg::FILL_W'(count_q);
    end
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.scan_done  = !dv_q && (rd_ptr_q == count_q);
  assign sts_o.shift_done = !dv_q && (rd_ptr_q == count_q);

endmodule

### rtl/core/min_pq_checker.sv
`timescale 1ns / 1ps

module min_pq_checker #(
  parameter int unsigned DEPTH = min_pq_pkg::DEPTH_DEFAULT
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [min_pq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [min_pq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser
);

  localparam logic SMALL_DEPTH = (DEPTH < 32);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result word changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while a request is still in work.");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == min_pq_pkg::ST_EMPTY) |->
      (m_axis_tdata[44:40] == '0) && (m_axis_tdata[39:0] == '0))
    else $error("Empty status with nonzero fill or data.");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == min_pq_pkg::ST_FULL) && SMALL_DEPTH |->
      (m_axis_tdata[44:40] == 5'(DEPTH)) && (m_axis_tdata[39:0] == '0))
    else $error("Full status with wrong fill or nonzero data.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && SMALL_DEPTH |->
      (m_axis_tdata[44:40] <= 5'(DEPTH)) && (m_axis_tdata[47:45] == '0))
    else $error("Fill level beyond the queue depth.");

endmodule

bind min_priority_queue min_pq_checker #(
  .DEPTH (DEPTH)
) u_min_pq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
